// ----- rtl/jls_pkg.sv -----
package jls_pkg;

   localparam int MAX_DIM = 16;
   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int N_W = $clog2(MAX_DIM + 1);
   localparam int SEQ_W = $clog2(MAX_DIM + 2);
   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

   localparam int CMD_W = 2;
   localparam int ROW_W = 4;
   localparam int COL_W = 4;
   localparam int VALUE_W = 32;
   localparam int INDEX_W = 4;
   localparam int STATUS_W = 2;
   localparam int SWEEPS_W = 16;

   localparam int DIM_W = 5;
   localparam int ITER_W = 16;
   localparam int THR_W = 63;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 63;

   localparam int ACC_W = 56;
   localparam int NORM_W = 64;
   localparam int DVD_W = 63;
   localparam int DVS_W = 32;

   localparam logic [CMD_W-1:0] CMD_MATRIX = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RHS = 2'd1;
   localparam logic [CMD_W-1:0] CMD_GUESS = 2'd2;
   localparam logic [CMD_W-1:0] CMD_START = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_CONVERGED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LIMIT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DIVERGED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_PIVOT = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_DIMENSION = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITERATIONS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_SQ = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_INTERVAL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVERGENCE_LIMIT = 3'd4;

   typedef struct packed {
      logic load_x;
      logic load_rhs;
      logic shift_x;
      logic shift_next;
      logic shift_rhs;
      logic copy;
   } cell_ctrl_type;

   function automatic logic [NORM_W-1:0] sq_sat(input logic signed [VALUE_W:0] d);
      logic [VALUE_W:0] mag;
      mag = d[VALUE_W] ? (VALUE_W+1)'(-d) : (VALUE_W+1)'(d);
      if (mag[VALUE_W]) begin
         return '1;
      end
      return NORM_W'(mag[VALUE_W-1:0]) * NORM_W'(mag[VALUE_W-1:0]);
   endfunction

   function automatic logic [NORM_W-1:0] add_sat(input logic [NORM_W-1:0] a,
                                                 input logic [NORM_W-1:0] b);
      logic [NORM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[NORM_W] ? '1 : s[NORM_W-1:0];
   endfunction

endpackage

// ----- rtl/jls_if.sv -----
interface jls_req_if;
   import jls_pkg::*;
   logic valid;
   logic ready;
   logic [CMD_W-1:0] cmd;
   logic [ROW_W-1:0] row;
   logic [COL_W-1:0] col;
   logic signed [VALUE_W-1:0] value;
   modport source (output valid, cmd, row, col, value, input ready);
   modport sink (input valid, cmd, row, col, value, output ready);
endinterface

interface jls_rsp_if;
   import jls_pkg::*;
   logic valid;
   logic ready;
   logic [INDEX_W-1:0] index;
   logic signed [VALUE_W-1:0] solution;
   logic last;
   logic [STATUS_W-1:0] status;
   logic [SWEEPS_W-1:0] sweeps;
   modport source (output valid, index, solution, last, status, sweeps, input ready);
   modport sink (input valid, index, solution, last, status, sweeps, output ready);
endinterface

// ----- rtl/jls_ram.sv -----
module jls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/jls_cell.sv -----
module jls_cell (
   input  logic                           clock,
   input  jls_pkg::cell_ctrl_type         ctrl,
   input  logic                           sel,
   input  logic signed [jls_pkg::VALUE_W-1:0] load_value,
   input  logic signed [jls_pkg::VALUE_W-1:0] x_in,
   input  logic signed [jls_pkg::VALUE_W-1:0] next_in,
   input  logic signed [jls_pkg::VALUE_W-1:0] rhs_in,
   output logic signed [jls_pkg::VALUE_W-1:0] x_out,
   output logic signed [jls_pkg::VALUE_W-1:0] next_out,
   output logic signed [jls_pkg::VALUE_W-1:0] rhs_out
);
   import jls_pkg::*;

   logic signed [VALUE_W-1:0] x_ff;
   logic signed [VALUE_W-1:0] next_ff;
   logic signed [VALUE_W-1:0] rhs_ff;

   always_ff @(posedge clock) begin
      if (ctrl.copy) begin
         x_ff <= next_ff;
      end else if (ctrl.load_x && sel) begin
         x_ff <= load_value;
      end else if (ctrl.shift_x) begin
         x_ff <= x_in;
      end
      if (ctrl.shift_next) begin
         next_ff <= next_in;
      end
      if (ctrl.load_rhs && sel) begin
         rhs_ff <= load_value;
      end else if (ctrl.shift_rhs) begin
         rhs_ff <= rhs_in;
      end
   end

   assign x_out = x_ff;
   assign next_out = next_ff;
   assign rhs_out = rhs_ff;

endmodule

// ----- rtl/jls_div.sv -----
module jls_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [jls_pkg::DVD_W-1:0]   dividend,
   input  logic [jls_pkg::DVS_W-1:0]   divisor,
   output logic                        busy,
   output logic                        done,
   output logic [jls_pkg::DVD_W-1:0]   quotient
);
   import jls_pkg::*;

   localparam int CNT_W = $clog2(DVD_W);

   logic busy_ff;
   logic done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] dsr_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [DVS_W:0] trial;
   logic fit;

   always_comb begin
      trial = {rem_ff, quo_ff[DVD_W-1]};
      fit = trial >= {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= CNT_W'(DVD_W - 1);
            rem_ff <= '0;
            dsr_ff <= divisor;
            quo_ff <= dividend;
         end else if (busy_ff) begin
            rem_ff <= fit ? DVS_W'(trial - {1'b0, dsr_ff}) : DVS_W'(trial);
            quo_ff <= {quo_ff[DVD_W-2:0], fit};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/jacobi_linear_solver_unit.sv -----
// Load transactions (matrix, rhs, initial guess) are accepted one per cycle while
// the unit is idle. A start transaction runs a prepass; a sweep visits each row in use
// with row setup, the multiply-accumulate walk, the bit-serial divider and the norms,
// skips each unused row and then closes the sweep.
// Sixteen result slots follow at one per cycle when not stalled; then the unit idles.
// Reset idles control and sets the configuration to its defaults; the matrix RAM and the cells stay undefined.
module jacobi_linear_solver_unit (
   input  logic                            clock,
   input  logic                            reset,
   jls_req_if.sink                         req,
   jls_rsp_if.source                       rsp,
   input  logic                            csr_write_enable,
   input  logic [jls_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [jls_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import jls_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PRE, ST_PRE_DONE, ST_ROW_START, ST_MAC, ST_DIV_START, ST_DIV_WAIT,
      ST_NORM_STEP, ST_NORM_NOW, ST_NORM_ACC, ST_SWEEP_END, ST_OUT
   } state_type;

   localparam logic signed [ACC_W:0] NUM_LIM = (ACC_W+1)'(64'sd70368744177664);

   state_type state_ff;

   logic [DIM_W-1:0] dim_ff;
   logic [ITER_W-1:0] max_iter_ff;
   logic [THR_W-1:0] thr_ff;
   logic [ITER_W-1:0] chk_ff;
   logic [ITER_W-1:0] lim_ff;

   logic [N_W-1:0] n_ff;
   logic [ITER_W-1:0] chk_eff_ff;
   logic [ITER_W-1:0] chk_cnt_ff;
   logic [ITER_W-1:0] k_ff;
   logic [ITER_W-1:0] rise_ff;
   logic [SWEEPS_W-1:0] sweep_cnt_ff;
   logic [NORM_W-1:0] prev_ff;
   logic [NORM_W-1:0] norm_ff;
   logic [NORM_W-1:0] step_ff;
   logic [NORM_W-1:0] now_ff;
   logic [STATUS_W-1:0] status_ff;
   logic zero_ff;

   logic [SEQ_W-1:0] cnt_ff;
   logic [IDX_W-1:0] i_ff;
   logic [IDX_W-1:0] out_i_ff;

   logic s1_valid_ff;
   logic s2_valid_ff;
   logic [IDX_W-1:0] s1_j_ff;
   logic [IDX_W-1:0] s2_j_ff;
   logic signed [VALUE_W-1:0] x_d_ff;
   logic signed [2*VALUE_W-1:0] prod_ff;
   logic [NORM_W-1:0] sq_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [VALUE_W-1:0] piv_ff;
   logic signed [VALUE_W-1:0] cur_ff;
   logic signed [VALUE_W-1:0] new_ff;
   logic neg_ff;

   logic rsp_valid_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic signed [VALUE_W-1:0] rsp_solution_ff;
   logic rsp_last_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SWEEPS_W-1:0] rsp_sweeps_ff;

   cell_ctrl_type cell_ctrl;
   logic [MAX_DIM-1:0] load_sel;
   logic signed [VALUE_W-1:0] x_q [MAX_DIM];
   logic signed [VALUE_W-1:0] next_q [MAX_DIM];
   logic signed [VALUE_W-1:0] rhs_q [MAX_DIM];
   logic signed [VALUE_W-1:0] next_push;

   logic ram_we;
   logic [ADDR_W-1:0] ram_wa;
   logic [ADDR_W-1:0] ram_ra;
   logic [VALUE_W-1:0] ram_rd;
   logic signed [VALUE_W-1:0] ram_rd_s;

   logic div_start;
   logic div_busy;
   logic div_done;
   logic [DVD_W-1:0] div_q;
   logic [DVD_W-1:0] dvd;
   logic [DVS_W-1:0] dvs;
   logic num_neg;

   logic req_fire;
   logic out_adv;
   logic [N_W-1:0] n_eff;
   logic signed [ACC_W:0] num;
   logic signed [ACC_W:0] num_c;
   logic [ACC_W:0] num_mag;
   logic signed [VALUE_W:0] piv_ext;
   logic [VALUE_W:0] piv_mag;
   logic signed [VALUE_W-1:0] new_sat;
   logic cnt_run;
   logic conv;
   logic chk_hit;
   logic rising;
   logic diverge;
   logic [ITER_W-1:0] k_next;
   logic [ITER_W:0] chk_cnt_inc;

   assign req_fire = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign out_adv = !rsp_valid_ff || rsp.ready;
   assign cnt_run = cnt_ff < SEQ_W'(MAX_DIM);
   assign ram_rd_s = ram_rd;

   always_comb begin
      if (dim_ff == '0) begin
         n_eff = N_W'(1);
      end else if (32'(dim_ff) > MAX_DIM) begin
         n_eff = N_W'(MAX_DIM);
      end else begin
         n_eff = N_W'(dim_ff);
      end
   end

   always_comb begin
      num = (ACC_W+1)'(rhs_q[0]) - (ACC_W+1)'(acc_ff);
      if (num > NUM_LIM) begin
         num_c = NUM_LIM;
      end else if (num < -NUM_LIM) begin
         num_c = -NUM_LIM;
      end else begin
         num_c = num;
      end
      num_neg = num_c < 0;
      num_mag = num_neg ? (ACC_W+1)'(-num_c) : (ACC_W+1)'(num_c);
      dvd = {num_mag[46:0], 16'b0};
      piv_ext = (VALUE_W+1)'(piv_ff);
      piv_mag = piv_ext[VALUE_W] ? (VALUE_W+1)'(-piv_ext) : (VALUE_W+1)'(piv_ext);
      dvs = piv_mag[DVS_W-1:0];
      if (!neg_ff) begin
         new_sat = (div_q > DVD_W'(32'h7fff_ffff)) ? 32'sh7fff_ffff
                                                   : VALUE_W'(div_q[VALUE_W-1:0]);
      end else begin
         new_sat = (div_q >= DVD_W'(33'h1_0000_0000 >> 1)) ? 32'sh8000_0000
                                                           : VALUE_W'(-div_q[VALUE_W-1:0]);
      end
   end

   always_comb begin
      conv = step_ff < NORM_W'(thr_ff);
      chk_hit = chk_cnt_ff == '0;
      rising = now_ff > prev_ff;
      diverge = !conv && chk_hit && rising && (rise_ff >= lim_ff);
      k_next = k_ff + 1'b1;
      chk_cnt_inc = (ITER_W+1)'(chk_cnt_ff) + 1'b1;
   end

   always_comb begin
      cell_ctrl = '0;
      load_sel = '0;
      ram_we = 1'b0;
      ram_wa = ADDR_W'(req.row) * ADDR_W'(MAX_DIM) + ADDR_W'(req.col);
      ram_ra = '0;
      div_start = 1'b0;
      next_push = new_ff;
      if (req_fire && req.cmd != CMD_START && 32'(req.row) < MAX_DIM) begin
         load_sel[IDX_W'(req.row)] = 1'b1;
         case (req.cmd)
            CMD_MATRIX: ram_we = 32'(req.col) < MAX_DIM;
            CMD_RHS: cell_ctrl.load_rhs = 1'b1;
            CMD_GUESS: cell_ctrl.load_x = 1'b1;
            default: ;
         endcase
      end
      case (state_ff)
         ST_PRE: begin
            ram_ra = ADDR_W'(cnt_ff[IDX_W-1:0]) * ADDR_W'(MAX_DIM + 1);
            cell_ctrl.shift_x = cnt_run;
         end
         ST_MAC: begin
            ram_ra = ADDR_W'(i_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(cnt_ff[IDX_W-1:0]);
            cell_ctrl.shift_x = cnt_run;
         end
         ST_ROW_START: begin
            if (N_W'(i_ff) >= n_ff) begin
               cell_ctrl.shift_next = 1'b1;
               cell_ctrl.shift_rhs = 1'b1;
               next_push = next_q[0];
            end
         end
         ST_DIV_START: div_start = 1'b1;
         ST_NORM_ACC: begin
            cell_ctrl.shift_next = 1'b1;
            cell_ctrl.shift_rhs = 1'b1;
         end
         ST_SWEEP_END: cell_ctrl.copy = 1'b1;
         ST_OUT: cell_ctrl.shift_x = out_adv;
         default: ;
      endcase
   end

   for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
      logic signed [VALUE_W-1:0] next_src;
      if (g == MAX_DIM - 1) begin : g_tail
         assign next_src = next_push;
      end else begin : g_body
         assign next_src = next_q[g+1];
      end
      jls_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .sel        (load_sel[g]),
         .load_value (req.value),
         .x_in       (x_q[(g + 1) % MAX_DIM]),
         .next_in    (next_src),
         .rhs_in     (rhs_q[(g + 1) % MAX_DIM]),
         .x_out      (x_q[g]),
         .next_out   (next_q[g]),
         .rhs_out    (rhs_q[g])
      );
   end

   jls_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_DIM * MAX_DIM)) u_matrix (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (req.value),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   jls_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd),
      .divisor  (dvs),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      s1_j_ff <= cnt_ff[IDX_W-1:0];
      x_d_ff <= x_q[0];
      s2_j_ff <= s1_j_ff;
      prod_ff <= ram_rd_s * x_d_ff;
      if (state_ff == ST_PRE) begin
         sq_ff <= sq_sat((VALUE_W+1)'(x_d_ff));
      end else if (state_ff == ST_NORM_STEP) begin
         sq_ff <= sq_sat((VALUE_W+1)'(new_ff) - (VALUE_W+1)'(cur_ff));
      end else if (state_ff == ST_NORM_NOW) begin
         sq_ff <= sq_sat((VALUE_W+1)'(new_ff));
      end
      if (reset) begin
         state_ff <= ST_IDLE;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dim_ff <= DIM_W'(16);
         max_iter_ff <= ITER_W'(100);
         thr_ff <= '0;
         chk_ff <= ITER_W'(1);
         lim_ff <= ITER_W'(3);
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DIMENSION: dim_ff <= csr_write_data[DIM_W-1:0];
               CSR_MAX_ITERATIONS: max_iter_ff <= csr_write_data[ITER_W-1:0];
               CSR_THRESHOLD_SQ: thr_ff <= csr_write_data[THR_W-1:0];
               CSR_CHECK_INTERVAL: chk_ff <= csr_write_data[ITER_W-1:0];
               CSR_DIVERGENCE_LIMIT: lim_ff <= csr_write_data[ITER_W-1:0];
               default: ;
            endcase
         end
         s1_valid_ff <= (state_ff == ST_PRE || state_ff == ST_MAC) && cnt_run;
         s2_valid_ff <= s1_valid_ff;
         if (state_ff == ST_PRE && s1_valid_ff && N_W'(s1_j_ff) < n_ff && ram_rd == '0) begin
            zero_ff <= 1'b1;
         end
         if (state_ff == ST_MAC && s1_valid_ff && s1_j_ff == i_ff) begin
            piv_ff <= ram_rd_s;
            cur_ff <= x_d_ff;
         end
         if (s2_valid_ff && N_W'(s2_j_ff) < n_ff) begin
            if (state_ff == ST_PRE) begin
               norm_ff <= add_sat(norm_ff, sq_ff);
            end else if (s2_j_ff != i_ff) begin
               acc_ff <= acc_ff + ACC_W'($signed(prod_ff[2*VALUE_W-1:16]));
            end
         end
         if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire && req.cmd == CMD_START) begin
                  n_ff <= n_eff;
                  chk_eff_ff <= (chk_ff == '0) ? ITER_W'(1) : chk_ff;
                  cnt_ff <= '0;
                  norm_ff <= '0;
                  zero_ff <= 1'b0;
                  state_ff <= ST_PRE;
               end
            end
            ST_PRE: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == SEQ_W'(MAX_DIM + 1)) begin
                  state_ff <= ST_PRE_DONE;
               end
            end
            ST_PRE_DONE: begin
               prev_ff <= norm_ff;
               rise_ff <= '0;
               sweep_cnt_ff <= '0;
               k_ff <= '0;
               chk_cnt_ff <= '0;
               out_i_ff <= '0;
               i_ff <= '0;
               step_ff <= '0;
               now_ff <= '0;
               if (max_iter_ff == '0) begin
                  status_ff <= STATUS_LIMIT;
                  state_ff <= ST_OUT;
               end else if (zero_ff) begin
                  status_ff <= STATUS_ZERO_PIVOT;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_ROW_START;
               end
            end
            ST_ROW_START: begin
               if (N_W'(i_ff) < n_ff) begin
                  cnt_ff <= '0;
                  acc_ff <= '0;
                  state_ff <= ST_MAC;
               end else begin
                  i_ff <= i_ff + 1'b1;
                  if (i_ff == IDX_W'(MAX_DIM - 1)) begin
                     state_ff <= ST_SWEEP_END;
                  end
               end
            end
            ST_MAC: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == SEQ_W'(MAX_DIM + 1)) begin
                  state_ff <= ST_DIV_START;
               end
            end
            ST_DIV_START: begin
               neg_ff <= num_neg ^ piv_ff[VALUE_W-1];
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  new_ff <= new_sat;
                  state_ff <= ST_NORM_STEP;
               end
            end
            ST_NORM_STEP: state_ff <= ST_NORM_NOW;
            ST_NORM_NOW: begin
               step_ff <= add_sat(step_ff, sq_ff);
               state_ff <= ST_NORM_ACC;
            end
            ST_NORM_ACC: begin
               now_ff <= add_sat(now_ff, sq_ff);
               i_ff <= i_ff + 1'b1;
               state_ff <= (i_ff == IDX_W'(MAX_DIM - 1)) ? ST_SWEEP_END : ST_ROW_START;
            end
            ST_SWEEP_END: begin
               sweep_cnt_ff <= k_next;
               chk_cnt_ff <= (chk_cnt_inc == (ITER_W+1)'(chk_eff_ff)) ? '0
                                                                       : chk_cnt_inc[ITER_W-1:0];
               if (!conv && chk_hit) begin
                  if (rising) begin
                     if (rise_ff != '1) begin
                        rise_ff <= rise_ff + 1'b1;
                     end
                  end else begin
                     rise_ff <= '0;
                  end
                  prev_ff <= now_ff;
               end
               k_ff <= k_next;
               i_ff <= '0;
               step_ff <= '0;
               now_ff <= '0;
               out_i_ff <= '0;
               if (conv) begin
                  status_ff <= STATUS_CONVERGED;
                  state_ff <= ST_OUT;
               end else if (diverge) begin
                  status_ff <= STATUS_DIVERGED;
                  state_ff <= ST_OUT;
               end else if (k_next == max_iter_ff) begin
                  status_ff <= STATUS_LIMIT;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_ROW_START;
               end
            end
            ST_OUT: begin
               if (out_adv) begin
                  rsp_valid_ff <= N_W'(out_i_ff) < n_ff;
                  rsp_index_ff <= INDEX_W'(out_i_ff);
                  rsp_solution_ff <= x_q[0];
                  rsp_last_ff <= N_W'(out_i_ff) == n_ff - 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_sweeps_ff <= sweep_cnt_ff;
                  out_i_ff <= out_i_ff + 1'b1;
                  if (out_i_ff == IDX_W'(MAX_DIM - 1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.index = rsp_index_ff;
   assign rsp.solution = rsp_solution_ff;
   assign rsp.last = rsp_last_ff;
   assign rsp.status = rsp_status_ff;
   assign rsp.sweeps = rsp_sweeps_ff;

`ifndef ASSERT_OFF
   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_busy)
      else $error("divider busy while idle");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider finished outside its wait state");
   a_pivot_sweeps: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == STATUS_ZERO_PIVOT) |-> (rsp.sweeps == '0))
      else $error("zero pivot reported with sweeps run");
`endif

endmodule
